FILE: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

FILE: src/rsa_me_pkg.sv
`default_nettype none

package rsa_me_pkg;

   localparam int WORD_W      = 32;
   localparam int CSR_ADDR_W  = 4;
   localparam int PRIME_REG_W = 16;
   localparam int UPC_W       = 4;

   localparam logic [1:0] REG_PRIME_P  = 2'd0;
   localparam logic [1:0] REG_PRIME_Q  = 2'd1;
   localparam logic [1:0] REG_EXPONENT = 2'd2;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_DBL,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [2:0] {
      LD_NONE,
      LD_INIT,
      LD_SAVE_M,
      LD_SQ,
      LD_MUL,
      LD_C_ACC,
      LD_NEXT_E,
      LD_OUT
   } ld_type;

   typedef enum logic [2:0] {
      J_NONE,
      J_N_SMALL,
      J_CNT_MORE,
      J_EBIT_ZERO,
      J_EXP_MORE,
      J_GCD_BUSY,
      J_OUT_BLOCKED
   } jmp_type;

   typedef struct packed {
      acc_op_type       acc_op;
      ld_type           ld;
      logic             gcd_start;
      jmp_type          jmp;
      logic [UPC_W-1:0] target;
      logic             last;
   } ctrl_word_type;

   typedef struct packed {
      logic n_small;
      logic cnt_last;
      logic ebit;
      logic exp_last;
      logic out_blocked;
   } dp_status_type;

   typedef struct packed {
      logic busy;
      logic coprime;
   } gcd_status_type;

   localparam ctrl_word_type CTRL_NOP = '{
      acc_op:    ACC_HOLD,
      ld:        LD_NONE,
      gcd_start: 1'b0,
      jmp:       J_NONE,
      target:    '0,
      last:      1'b0
   };

endpackage

`default_nettype wire

FILE: src/rsa_me_if.sv
`default_nettype none

interface rsa_me_req_if;
   import rsa_me_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] message;

   modport source (output valid, output message, input ready);
   modport sink (input valid, input message, output ready);
endinterface

interface rsa_me_rsp_if;
   import rsa_me_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] ciphertext;
   logic              exponent_coprime;

   modport source (output valid, output ciphertext, output exponent_coprime, input ready);
   modport sink (input valid, input ciphertext, input exponent_coprime, output ready);
endinterface

`default_nettype wire

FILE: src/rsa_me_csr.sv
`default_nettype none

module rsa_me_csr #(
   parameter int P_W = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [rsa_me_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [rsa_me_pkg::WORD_W-1:0]      pwdata,
   output logic      [rsa_me_pkg::WORD_W-1:0]      prdata,
   output logic                                    pready,
   output logic      [rsa_me_pkg::WORD_W-1:0]      exponent,
   output logic      [2*P_W-1:0]                   modulus,
   output logic      [2*P_W-1:0]                   totient
);
   import rsa_me_pkg::*;

   localparam int NW = 2 * P_W;

   logic [P_W-1:0]    p_ff, p_in;
   logic [P_W-1:0]    q_ff, q_in;
   logic [WORD_W-1:0] e_ff, e_in;
   logic [NW-1:0]     n_ff, phi_ff;
   logic [P_W-1:0]    pm1, qm1;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      p_in = p_ff;
      q_in = q_ff;
      e_in = e_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PRIME_P: p_in = pwdata[P_W-1:0];
            REG_PRIME_Q: q_in = pwdata[P_W-1:0];
            REG_EXPONENT: e_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PRIME_P: prdata = WORD_W'(p_ff);
         REG_PRIME_Q: prdata = WORD_W'(q_ff);
         REG_EXPONENT: prdata = e_ff;
         default: prdata = '0;
      endcase
   end

   // saturate at zero for primes below one
   assign pm1 = (p_ff != '0) ? p_ff - 1'b1 : '0;
   assign qm1 = (q_ff != '0) ? q_ff - 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= P_W'(61);
         q_ff <= P_W'(53);
         e_ff <= WORD_W'(17);
      end else begin
         p_ff <= p_in;
         q_ff <= q_in;
         e_ff <= e_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= {{P_W{1'b0}}, p_ff} * {{P_W{1'b0}}, q_ff};
      phi_ff <= {{P_W{1'b0}}, pm1} * {{P_W{1'b0}}, qm1};
   end

   assign exponent = e_ff;
   assign modulus  = n_ff;
   assign totient  = phi_ff;

endmodule

`default_nettype wire

FILE: src/rsa_me_gcd.sv
`default_nettype none

module rsa_me_gcd #(
   parameter int PHI_W = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rsa_me_pkg::WORD_W-1:0] exponent,
   input  wire logic [PHI_W-1:0]              totient,
   output rsa_me_pkg::gcd_status_type         status
);
   import rsa_me_pkg::*;

   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] y_ff, y_in;
   logic              busy_ff, busy_in;
   logic              cop_ff, cop_in;
   logic              x_ge_y;
   logic [WORD_W-1:0] diff;

   assign x_ge_y = x_ff >= y_ff;
   assign diff   = x_ge_y ? x_ff - y_ff : y_ff - x_ff;

   // binary gcd, only the test for one is kept
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      busy_in = busy_ff;
      cop_in  = cop_ff;
      if (start) begin
         x_in    = exponent;
         y_in    = WORD_W'(totient);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff == '0) begin
            cop_in  = (y_ff == WORD_W'(1));
            busy_in = 1'b0;
         end else if (y_ff == '0) begin
            cop_in  = (x_ff == WORD_W'(1));
            busy_in = 1'b0;
         end else if (!x_ff[0] && !y_ff[0]) begin
            cop_in  = 1'b0;
            busy_in = 1'b0;
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ge_y) begin
            x_in = diff;
         end else begin
            y_in = diff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cop_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cop_ff  <= cop_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign status.busy    = busy_ff;
   assign status.coprime = cop_ff;

endmodule

`default_nettype wire

FILE: src/rsa_me_dp.sv
`default_nettype none
`include "assert_macros.svh"

module rsa_me_dp #(
   parameter int P_W = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [rsa_me_pkg::WORD_W-1:0] message,
   input  wire logic [rsa_me_pkg::WORD_W-1:0] exponent,
   input  wire logic [2*P_W-1:0]              modulus,
   input  wire logic                          coprime,
   input  wire rsa_me_pkg::ctrl_word_type     ctrl,
   input  wire logic                          rsp_ready,
   output rsa_me_pkg::dp_status_type          status,
   output logic                               rsp_valid,
   output logic      [rsa_me_pkg::WORD_W-1:0] ciphertext,
   output logic                               exponent_coprime
);
   import rsa_me_pkg::*;

   localparam int NW    = 2 * P_W;
   localparam int CNT_W = $clog2(WORD_W);

   logic [NW-1:0]     acc_ff, acc_in;
   logic [NW-1:0]     a_ff, a_in;
   logic [NW-1:0]     m_ff, m_in;
   logic [NW-1:0]     c_ff, c_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic [WORD_W-1:0] esh_ff, esh_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  ecnt_ff, ecnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] cipher_ff, cipher_in;
   logic              cop_ff, cop_in;

   logic [NW-1:0]     add_y;
   logic [NW:0]       sum, diff;
   logic [NW-1:0]     mod_res;
   logic              n_small, out_blocked;

   assign n_small     = (modulus[NW-1:1] == '0);
   assign out_blocked = rsp_valid_ff && !rsp_ready;

   // shared add and restoring reduction
   assign add_y   = (ctrl.acc_op == ACC_DBL) ? acc_ff : a_ff;
   assign sum     = {1'b0, acc_ff} + {1'b0, add_y};
   assign diff    = sum - {1'b0, modulus};
   assign mod_res = (sum >= {1'b0, modulus}) ? diff[NW-1:0] : sum[NW-1:0];

   always_comb begin
      acc_in       = acc_ff;
      a_in         = a_ff;
      m_in         = m_ff;
      c_in         = c_ff;
      b_in         = b_ff;
      esh_in       = esh_ff;
      cnt_in       = cnt_ff;
      ecnt_in      = ecnt_ff;
      cipher_in    = cipher_ff;
      cop_in       = cop_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         b_in = message;
      end

      case (ctrl.ld)
         LD_INIT: begin
            a_in   = NW'(1);
            acc_in = '0;
            cnt_in = '0;
            esh_in = exponent;
         end
         LD_SAVE_M: begin
            m_in    = acc_ff;
            c_in    = NW'(1);
            ecnt_in = '0;
         end
         LD_SQ: begin
            a_in   = c_ff;
            b_in   = WORD_W'(c_ff);
            acc_in = '0;
            cnt_in = '0;
         end
         LD_MUL: begin
            a_in   = m_ff;
            b_in   = WORD_W'(c_ff);
            acc_in = '0;
            cnt_in = '0;
         end
         LD_C_ACC: begin
            c_in = acc_ff;
         end
         LD_NEXT_E: begin
            esh_in  = esh_ff << 1;
            ecnt_in = ecnt_ff + 1'b1;
         end
         LD_OUT: begin
            if (!out_blocked) begin
               cipher_in    = n_small ? '0 : WORD_W'(c_ff);
               cop_in       = coprime;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase

      case (ctrl.acc_op)
         ACC_DBL: begin
            acc_in = mod_res;
         end
         ACC_ADD: begin
            if (b_ff[WORD_W-1]) begin
               acc_in = mod_res;
            end
            b_in   = b_ff << 1;
            cnt_in = cnt_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      a_ff      <= a_in;
      m_ff      <= m_in;
      c_ff      <= c_in;
      b_ff      <= b_in;
      esh_ff    <= esh_in;
      cnt_ff    <= cnt_in;
      ecnt_ff   <= ecnt_in;
      cipher_ff <= cipher_in;
      cop_ff    <= cop_in;
   end

   assign status.n_small     = n_small;
   assign status.cnt_last    = (cnt_ff == '1);
   assign status.ebit        = esh_ff[WORD_W-1];
   assign status.exp_last    = (ecnt_ff == '1);
   assign status.out_blocked = out_blocked;

   assign rsp_valid        = rsp_valid_ff;
   assign ciphertext       = cipher_ff;
   assign exponent_coprime = cop_ff;

   `ASSERT_PROP(a_operands_reduced, clock, reset, (ctrl.acc_op != ACC_HOLD) |-> (acc_ff < modulus) && (a_ff < modulus), "operand not reduced below modulus")
   `ASSERT_PROP(a_result_from_output_step, clock, reset, $rose(rsp_valid_ff) |-> $past(ctrl.ld == LD_OUT), "result raised outside output step")

endmodule

`default_nettype wire

FILE: src/rsa_me_seq.sv
`default_nettype none
`include "assert_macros.svh"

module rsa_me_seq (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire rsa_me_pkg::dp_status_type  dp_status,
   input  wire rsa_me_pkg::gcd_status_type gcd_status,
   output rsa_me_pkg::ctrl_word_type       ctrl,
   output logic                            idle
);
   import rsa_me_pkg::*;

   localparam logic [UPC_W-1:0] UPC_INIT   = 4'd0;
   localparam logic [UPC_W-1:0] UPC_CHKN   = 4'd1;
   localparam logic [UPC_W-1:0] UPC_RDBL   = 4'd2;
   localparam logic [UPC_W-1:0] UPC_RADD   = 4'd3;
   localparam logic [UPC_W-1:0] UPC_SAVEM  = 4'd4;
   localparam logic [UPC_W-1:0] UPC_SQLD   = 4'd5;
   localparam logic [UPC_W-1:0] UPC_SQDBL  = 4'd6;
   localparam logic [UPC_W-1:0] UPC_SQADD  = 4'd7;
   localparam logic [UPC_W-1:0] UPC_SQSV   = 4'd8;
   localparam logic [UPC_W-1:0] UPC_MLD    = 4'd9;
   localparam logic [UPC_W-1:0] UPC_MDBL   = 4'd10;
   localparam logic [UPC_W-1:0] UPC_MADD   = 4'd11;
   localparam logic [UPC_W-1:0] UPC_MSV    = 4'd12;
   localparam logic [UPC_W-1:0] UPC_NEXT   = 4'd13;
   localparam logic [UPC_W-1:0] UPC_WAITG  = 4'd14;
   localparam logic [UPC_W-1:0] UPC_OUT    = 4'd15;

   function automatic ctrl_word_type make_word(input acc_op_type a, input ld_type l,
                                               input logic g, input jmp_type j,
                                               input logic [UPC_W-1:0] t, input logic e);
      ctrl_word_type w;
      w.acc_op    = a;
      w.ld        = l;
      w.gcd_start = g;
      w.jmp       = j;
      w.target    = t;
      w.last      = e;
      return w;
   endfunction

   function automatic ctrl_word_type rom_word(input logic [UPC_W-1:0] addr);
      ctrl_word_type w;
      case (addr)
         UPC_INIT:  w = make_word(ACC_HOLD, LD_INIT, 1'b0, J_NONE, UPC_INIT, 1'b0);
         UPC_CHKN:  w = make_word(ACC_HOLD, LD_NONE, 1'b1, J_N_SMALL, UPC_WAITG, 1'b0);
         UPC_RDBL:  w = make_word(ACC_DBL, LD_NONE, 1'b0, J_NONE, UPC_INIT, 1'b0);
         UPC_RADD:  w = make_word(ACC_ADD, LD_NONE, 1'b0, J_CNT_MORE, UPC_RDBL, 1'b0);
         UPC_SAVEM: w = make_word(ACC_HOLD, LD_SAVE_M, 1'b0, J_NONE, UPC_INIT, 1'b0);
         UPC_SQLD:  w = make_word(ACC_HOLD, LD_SQ, 1'b0, J_NONE, UPC_INIT, 1'b0);
         UPC_SQDBL: w = make_word(ACC_DBL, LD_NONE, 1'b0, J_NONE, UPC_INIT, 1'b0);
         UPC_SQADD: w = make_word(ACC_ADD, LD_NONE, 1'b0, J_CNT_MORE, UPC_SQDBL, 1'b0);
         UPC_SQSV:  w = make_word(ACC_HOLD, LD_C_ACC, 1'b0, J_EBIT_ZERO, UPC_NEXT, 1'b0);
         UPC_MLD:   w = make_word(ACC_HOLD, LD_MUL, 1'b0, J_NONE, UPC_INIT, 1'b0);
         UPC_MDBL:  w = make_word(ACC_DBL, LD_NONE, 1'b0, J_NONE, UPC_INIT, 1'b0);
         UPC_MADD:  w = make_word(ACC_ADD, LD_NONE, 1'b0, J_CNT_MORE, UPC_MDBL, 1'b0);
         UPC_MSV:   w = make_word(ACC_HOLD, LD_C_ACC, 1'b0, J_NONE, UPC_INIT, 1'b0);
         UPC_NEXT:  w = make_word(ACC_HOLD, LD_NEXT_E, 1'b0, J_EXP_MORE, UPC_SQLD, 1'b0);
         UPC_WAITG: w = make_word(ACC_HOLD, LD_NONE, 1'b0, J_GCD_BUSY, UPC_WAITG, 1'b0);
         UPC_OUT:   w = make_word(ACC_HOLD, LD_OUT, 1'b0, J_OUT_BLOCKED, UPC_OUT, 1'b1);
         default:   w = CTRL_NOP;
      endcase
      return w;
   endfunction

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             busy_ff, busy_in;
   ctrl_word_type    word;
   logic             taken;

   always_comb begin
      word = busy_ff ? rom_word(upc_ff) : CTRL_NOP;
      case (word.jmp)
         J_N_SMALL:     taken = dp_status.n_small;
         J_CNT_MORE:    taken = !dp_status.cnt_last;
         J_EBIT_ZERO:   taken = !dp_status.ebit;
         J_EXP_MORE:    taken = !dp_status.exp_last;
         J_GCD_BUSY:    taken = gcd_status.busy;
         J_OUT_BLOCKED: taken = dp_status.out_blocked;
         default:       taken = 1'b0;
      endcase
   end

   always_comb begin
      upc_in  = upc_ff;
      busy_in = busy_ff;
      if (start) begin
         upc_in  = UPC_INIT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (taken) begin
            upc_in = word.target;
         end else if (word.last) begin
            busy_in = 1'b0;
         end else begin
            upc_in = upc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= UPC_INIT;
         busy_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         busy_ff <= busy_in;
      end
   end

   assign ctrl = word;
   assign idle = !busy_ff;

   `ASSERT_PROP(a_start_enters_init, clock, reset, start |=> busy_ff && (upc_ff == UPC_INIT), "transaction did not enter first step")
   `ASSERT_PROP(a_done_from_output, clock, reset, $fell(busy_ff) |-> ($past(upc_ff) == UPC_OUT), "program ended outside output step")
   `ASSERT_NEVER(a_no_start_when_busy, clock, reset, start && busy_ff, "transaction accepted while busy")

endmodule

`default_nettype wire

FILE: src/rsa_modular_exponentiation_core.sv
`default_nettype none

// Textbook RSA encryption of one 32-bit word per transaction: ciphertext is
// message to the power public_exponent modulo prime_p * prime_q, and
// exponent_coprime tells whether the exponent is coprime to (p-1)(q-1).
// Registers sit on the APB port at 0x0 (prime_p), 0x4 (prime_q) and 0x8
// (public_exponent); write them only while no transaction is in flight. A
// small microcode program drives one shared add/compare reduction unit: each
// modular multiply doubles, then conditionally adds, for each of 32 multiplier
// bits. A transaction runs one reduction of the message, 32 squarings and one
// multiply per set bit in the exponent. When the modulus is below two the
// result follows the gcd unit. The next message is accepted as soon as the
// result is in the output register.

module rsa_modular_exponentiation_core #(
   parameter int PRIME_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   rsa_me_req_if.sink                             req_ch,
   rsa_me_rsp_if.source                           rsp_ch,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [rsa_me_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [rsa_me_pkg::WORD_W-1:0]     pwdata,
   output logic      [rsa_me_pkg::WORD_W-1:0]     prdata,
   output logic                                   pready
);
   import rsa_me_pkg::*;

   localparam int P_W = (PRIME_WIDTH < PRIME_REG_W) ? PRIME_WIDTH : PRIME_REG_W;
   localparam int NW  = 2 * P_W;

   logic [WORD_W-1:0] exponent;
   logic [NW-1:0]     modulus;
   logic [NW-1:0]     totient;
   ctrl_word_type     ctrl;
   dp_status_type     dp_status;
   gcd_status_type    gcd_status;
   logic              idle;
   logic              accept;

   assign req_ch.ready = idle;
   assign accept       = req_ch.valid && idle;

   rsa_me_csr #(
      .P_W(P_W)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .exponent(exponent),
      .modulus(modulus),
      .totient(totient)
   );

   rsa_me_gcd #(
      .PHI_W(NW)
   ) u_gcd (
      .clock(clock),
      .reset(reset),
      .start(ctrl.gcd_start),
      .exponent(exponent),
      .totient(totient),
      .status(gcd_status)
   );

   rsa_me_seq u_seq (
      .clock(clock),
      .reset(reset),
      .start(accept),
      .dp_status(dp_status),
      .gcd_status(gcd_status),
      .ctrl(ctrl),
      .idle(idle)
   );

   rsa_me_dp #(
      .P_W(P_W)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .message(req_ch.message),
      .exponent(exponent),
      .modulus(modulus),
      .coprime(gcd_status.coprime),
      .ctrl(ctrl),
      .rsp_ready(rsp_ch.ready),
      .status(dp_status),
      .rsp_valid(rsp_ch.valid),
      .ciphertext(rsp_ch.ciphertext),
      .exponent_coprime(rsp_ch.exponent_coprime)
   );

endmodule

`default_nettype wire

FILE: verif/rsa_me_checker.sv
module rsa_me_checker #(
   parameter int PRIME_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [rsa_me_pkg::WORD_W-1:0]     req_message,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [rsa_me_pkg::WORD_W-1:0]     rsp_ciphertext,
   input  logic                              rsp_exponent_coprime,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [rsa_me_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rsa_me_pkg::WORD_W-1:0]     pwdata,
   output int                                mismatch_count,
   output int                                cipher_backlog
);
   import rsa_me_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned PRIME_MASK = (64'd1 << PRIME_WIDTH) - 64'd1;

   typedef struct packed {
      logic [WORD_W-1:0] ciphertext;
      logic              exponent_coprime;
   } cipher_result_type;

   cipher_result_type expected_ciphers[$];
   longint unsigned   key_p;
   longint unsigned   key_q;
   logic [31:0]       key_e;
   int                fail_total;
   int                backlog;

   assign mismatch_count = fail_total;
   assign cipher_backlog = backlog;

   function automatic cipher_result_type encrypt_word(input logic [WORD_W-1:0] msg);
      longint unsigned   modulus;
      longint unsigned   totient;
      longint unsigned   base;
      longint unsigned   acc;
      longint unsigned   ga;
      longint unsigned   gb;
      longint unsigned   gr;
      cipher_result_type res;
      int                i;
      modulus = key_p * key_q;
      totient = ((key_p > 0) ? key_p - 1 : 0) * ((key_q > 0) ? key_q - 1 : 0);
      acc = 0;
      if (modulus > 1) begin
         base = {32'd0, msg} % modulus;
         acc = 1;
         for (i = 31; i >= 0; i--) begin
            acc = (acc * acc) % modulus;
            if (key_e[i]) begin
               acc = (acc * base) % modulus;
            end
         end
      end
      ga = {32'd0, key_e};
      gb = totient;
      while (gb != 0) begin
         gr = ga % gb;
         ga = gb;
         gb = gr;
      end
      res.ciphertext = acc[WORD_W-1:0];
      res.exponent_coprime = (ga == 1);
      return res;
   endfunction

   always @(posedge clock) begin
      cipher_result_type want;
      if (reset) begin
         key_p = 61 & PRIME_MASK;
         key_q = 53 & PRIME_MASK;
         key_e = 32'd17;
         expected_ciphers.delete();
         fail_total = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_PRIME_P: begin
                  key_p = {48'd0, pwdata[15:0]} & PRIME_MASK;
               end
               REG_PRIME_Q: begin
                  key_q = {48'd0, pwdata[15:0]} & PRIME_MASK;
               end
               REG_EXPONENT: begin
                  key_e = pwdata;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_ciphers.size() == 0) begin
               $display("%0t unexpected transaction: ciphertext %h coprime %b", $time,
                        rsp_ciphertext, rsp_exponent_coprime);
               fail_total++;
            end else begin
               want = expected_ciphers.pop_front();
               if (rsp_ciphertext !== want.ciphertext) begin
                  $display("%0t ciphertext mismatch: expected %h, actual %h", $time,
                           want.ciphertext, rsp_ciphertext);
                  fail_total++;
               end
               if (rsp_exponent_coprime !== want.exponent_coprime) begin
                  $display("%0t exponent_coprime mismatch: expected %b, actual %b", $time,
                           want.exponent_coprime, rsp_exponent_coprime);
                  fail_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_ciphers.push_back(encrypt_word(req_message));
         end
      end
      backlog = expected_ciphers.size();
   end

endmodule

FILE: verif/tb_rsa_modular_exponentiation_core.sv
module tb_rsa_modular_exponentiation_core;
   import rsa_me_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRIME_WIDTH   = 16;
   localparam int RANDOM_ITEMS  = 140;
   localparam int LONG_HOLD     = 12000;
   localparam int TAIL_CYCLES   = 5000;
   localparam int CYCLE_LIMIT   = 4000000;
   localparam logic [15:0] PRIME_TABLE [16] = '{
      16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13, 16'd53, 16'd61,
      16'd251, 16'd257, 16'd4093, 16'd32749, 16'd40009, 16'd65497, 16'd65519, 16'd65521
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [WORD_W-1:0]     pwdata;
   wire  [WORD_W-1:0]     prdata;
   wire                   pready;
   int                    mismatches;
   int                    pending;
   int                    cycle_count;
   logic                  hold_request;
   logic [15:0]           key_p;
   logic [15:0]           key_q;
   logic [31:0]           key_e;

   rsa_me_req_if req_if ();
   rsa_me_rsp_if rsp_if ();

   rsa_modular_exponentiation_core #(
      .PRIME_WIDTH(PRIME_WIDTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   rsa_me_checker #(
      .PRIME_WIDTH(PRIME_WIDTH)
   ) cipher_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_if.valid),
      .req_ready            (req_if.ready),
      .req_message          (req_if.message),
      .rsp_valid            (rsp_if.valid),
      .rsp_ready            (rsp_if.ready),
      .rsp_ciphertext       (rsp_if.ciphertext),
      .rsp_exponent_coprime (rsp_if.exponent_coprime),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .pready               (pready),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .mismatch_count       (mismatches),
      .cipher_backlog       (pending)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [15:0] pick_prime();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return PRIME_TABLE[$urandom_range(0, 15)];
      if (roll < 85) return 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd2;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [31:0] pick_exponent();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30) return $urandom;
      if (roll < 55) return $urandom_range(0, 70);
      if (roll < 70) return 32'd65537;
      if (roll < 85) begin
         case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            default: return 32'h8000_0000;
         endcase
      end
      return (32'd1 << $urandom_range(0, 31)) | 32'd1;
   endfunction

   function automatic logic [31:0] pick_message();
      longint unsigned modulus;
      int              roll;
      modulus = key_p * key_q;
      roll = $urandom_range(0, 99);
      if (roll < 60 || modulus == 0) return $urandom;
      if (roll < 75) return $urandom_range(0, 32'(modulus - 1));
      if (roll < 85) return 32'(modulus * $urandom_range(1, 3));
      if (roll < 92) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
      return ($urandom_range(0, 1) != 0) ? 32'd1 : 32'(modulus - 1);
   endfunction

   task automatic send_message(input logic [WORD_W-1:0] msg);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.message <= msg;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [WORD_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_keys(input logic [15:0] p, input logic [15:0] q, input logic [31:0] e);
      drain_pipeline();
      key_p = p;
      key_q = q;
      key_e = e;
      csr_write(REG_PRIME_P, {16'($urandom), p});
      csr_write(REG_PRIME_Q, {16'($urandom), q});
      csr_write(REG_EXPONENT, e);
   endtask

   // result side: random back-pressure plus one long hold-off
   initial begin
      int stretch;
      bit hold_done;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            stretch = pick_gap();
            if (stretch == 0) begin
               rsp_if.ready <= 1'b1;
            end else begin
               rsp_if.ready <= 1'b0;
               repeat (stretch - 1) @(negedge clock);
            end
         end
      end
   end

   initial begin
      int sent;
      int batch;
      int k;
      reset          = 1'b1;
      cycle_count    = 0;
      hold_request   = 1'b0;
      req_if.valid   = 1'b0;
      req_if.message = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      key_p          = 16'd61;
      key_q          = 16'd53;
      key_e          = 32'd17;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset keys, message extremes and the modulus with its neighbours
      send_message(32'd0);
      send_message(32'd1);
      send_message(32'hFFFF_FFFF);
      send_message(32'd3232);
      send_message(32'd3233);
      send_message(32'd3234);
      // widest 16-bit prime inputs, all exponent bits set
      set_keys(16'hFFFF, 16'd65521, 32'hFFFF_FFFF);
      send_message(32'hFFFF_FFFF);
      send_message(32'h8000_0000);
      // zero exponent
      set_keys(16'd65521, 16'd65519, 32'd0);
      send_message(32'd12345);
      send_message(32'd0);
      // zero modulus
      set_keys(16'd0, 16'd53, 32'd65537);
      send_message(32'd7);
      set_keys(16'd53, 16'd0, 32'd0);
      send_message(32'hFFFF_FFFF);
      // modulus of one
      set_keys(16'd1, 16'd1, 32'd1);
      send_message(32'd5);
      // prime below two, totient zero
      set_keys(16'd1, 16'd13, 32'd1);
      send_message(32'd100);
      // zero exponent with totient one, then an exponent sharing a factor with the totient
      set_keys(16'd2, 16'd2, 32'd0);
      send_message(32'd3);
      set_keys(16'd2, 16'd3, 32'd2);
      send_message(32'd5);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == 0) begin
            set_keys(PRIME_TABLE[$urandom_range(8, 15)], PRIME_TABLE[$urandom_range(8, 15)],
                     $urandom);
            hold_request = 1'b1;
            batch = 12;
         end else begin
            set_keys(pick_prime(), pick_prime(), pick_exponent());
            batch = $urandom_range(4, 16);
         end
         for (k = 0; k < batch && sent < RANDOM_ITEMS; k++) begin
            send_message(pick_message());
            sent++;
         end
      end

      drain_pipeline();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/rsa_me_pkg.sv
src/rsa_me_if.sv
src/rsa_me_csr.sv
src/rsa_me_gcd.sv
src/rsa_me_dp.sv
src/rsa_me_seq.sv
src/rsa_modular_exponentiation_core.sv
verif/rsa_me_checker.sv
verif/tb_rsa_modular_exponentiation_core.sv
